/* rtl/bwlp_pkg.sv */
// Shared types and fixed-point constants for the fourth-order Butterworth low-pass filter.
`default_nettype none

package bwlp_pkg;

  // Reciprocal gain, unsigned Q0.40
  localparam int INV_W    = 30;
  localparam int INV_FRAC = 40;
  // Feedback coefficients, signed Q3.28
  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = 28;
  // Past outputs are multiplied in a high and a low piece at this bit
  localparam int SPLIT = 20;
  localparam int OUT_W = 24;

  typedef logic [INV_W-1:0]         inv_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic {
    CORNER_1HZ    = 1'b0,
    CORNER_HALFHZ = 1'b1
  } corner_e;

  localparam logic [63:0] TWO_40 = 64'd1 << 40;

  localparam logic [63:0] INV_1HZ_RAW =
    (TWO_40 * 64'd1000000 + 64'd1200194323) / 64'd2400388646;
  localparam logic [63:0] INV_HALFHZ_RAW =
    (TWO_40 * 64'd100000 + 64'd1600564581) / 64'd3201129162;

  localparam inv_t INV_GAIN_1HZ    = inv_t'(INV_1HZ_RAW);
  localparam inv_t INV_GAIN_HALFHZ = inv_t'(INV_HALFHZ_RAW);

  localparam logic [63:0] Q28   = 64'd268435456;
  localparam logic [63:0] CHALF = 64'd5000000000;
  localparam logic [63:0] CDEN  = 64'd10000000000;

  localparam logic [63:0] CM_1HZ_0 = (64'd4382651423 * Q28 + CHALF) / CDEN;
  localparam logic [63:0] CM_1HZ_1 = (64'd21121553551 * Q28 + CHALF) / CDEN;
  localparam logic [63:0] CM_1HZ_2 = (64'd38611943490 * Q28 + CHALF) / CDEN;
  localparam logic [63:0] CM_1HZ_3 = (64'd31806385489 * Q28 + CHALF) / CDEN;
  localparam logic [63:0] CM_HHZ_0 = (64'd6630104844 * Q28 + CHALF) / CDEN;
  localparam logic [63:0] CM_HHZ_1 = (64'd29240526562 * Q28 + CHALF) / CDEN;
  localparam logic [63:0] CM_HHZ_2 = (64'd48512758825 * Q28 + CHALF) / CDEN;
  localparam logic [63:0] CM_HHZ_3 = (64'd35897338871 * Q28 + CHALF) / CDEN;

  // Index 0 weights the oldest output, index 3 the newest
  localparam coef_t FB_COEF_1HZ [4] = '{
    -coef_t'(CM_1HZ_0), coef_t'(CM_1HZ_1), -coef_t'(CM_1HZ_2), coef_t'(CM_1HZ_3)
  };
  localparam coef_t FB_COEF_HALFHZ [4] = '{
    -coef_t'(CM_HHZ_0), coef_t'(CM_HHZ_1), -coef_t'(CM_HHZ_2), coef_t'(CM_HHZ_3)
  };

endpackage

`default_nettype wire

/* rtl/bwlp_ff.sv */
// Feedforward path: raw-sample history, binomial tap sum and scaling by the reciprocal gain.
`default_nettype none

module bwlp_ff #(
  parameter int SAMPLE_WIDTH = 10,
  parameter int FRAC_BITS    = 24
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              load_i,
  input  wire logic [SAMPLE_WIDTH-1:0]           sample_i,
  input  wire bwlp_pkg::corner_e                 corner_i,
  output logic      [SAMPLE_WIDTH+FRAC_BITS-1:0] ffq_o
);

  localparam int SUM_W = SAMPLE_WIDTH + 4;
  localparam int PRW   = SUM_W + bwlp_pkg::INV_W + 1;
  localparam int FFW   = SAMPLE_WIDTH + FRAC_BITS;
  localparam logic [PRW-1:0] FF_ROUND =
    PRW'(1) << (bwlp_pkg::INV_FRAC - 1 - FRAC_BITS);

  logic [SAMPLE_WIDTH-1:0] xh_q [4];
  logic [FFW-1:0]          ffq_q;
  logic [FFW-1:0]          ffq_d;
  logic [SUM_W-1:0]        ffsum;
  bwlp_pkg::inv_t          inv;
  logic [PRW-1:0]          prod;

  always_comb begin
    ffsum = SUM_W'(xh_q[0]) + SUM_W'(sample_i)
          + (SUM_W'(4) * (SUM_W'(xh_q[1]) + SUM_W'(xh_q[3])))
          + (SUM_W'(6) * SUM_W'(xh_q[2]));
    inv   = (corner_i == bwlp_pkg::CORNER_HALFHZ) ? bwlp_pkg::INV_GAIN_HALFHZ
                                                  : bwlp_pkg::INV_GAIN_1HZ;
    prod  = PRW'(ffsum) * PRW'(inv) + FF_ROUND;
    ffq_d = FFW'(prod >> (bwlp_pkg::INV_FRAC - FRAC_BITS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) xh_q[i] <= '0;
    end else if (load_i) begin
      // advance the sample history
      for (int i = 0; i < 3; i++) xh_q[i] <= xh_q[i+1];
      xh_q[3] <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ffq_q <= ffq_d;
    end
  end

  assign ffq_o = ffq_q;

endmodule

`default_nettype wire

/* rtl/bwlp_fb_cell.sv */
// One feedback tap of the transposed chain: each corner's coefficient times newest output plus neighbor sum.
`default_nettype none

module bwlp_fb_cell #(
  parameter int HW = 36,
  parameter int PW = 70
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic signed [HW-1:0]  y_i,
  input  wire bwlp_pkg::coef_t       coef_1hz_i,
  input  wire bwlp_pkg::coef_t       coef_halfhz_i,
  input  wire logic signed [PW-1:0]  sum_1hz_i,
  input  wire logic signed [PW-1:0]  sum_halfhz_i,
  output logic signed [PW-1:0]       sum_1hz_o,
  output logic signed [PW-1:0]       sum_halfhz_o
);

  localparam int YHW = HW - bwlp_pkg::SPLIT;
  localparam int PHW = bwlp_pkg::COEF_W + YHW;
  localparam int PLW = bwlp_pkg::COEF_W + bwlp_pkg::SPLIT + 1;

  logic signed [YHW-1:0]              yh;
  logic signed [bwlp_pkg::SPLIT:0]    yl;
  logic signed [PHW-1:0]              ph_1hz, ph_halfhz;
  logic signed [PLW-1:0]              pl_1hz, pl_halfhz;
  logic signed [PW-1:0]               acc_1hz_q, acc_1hz_d;
  logic signed [PW-1:0]               acc_halfhz_q, acc_halfhz_d;

  always_comb begin
    yh        = y_i[HW-1:bwlp_pkg::SPLIT];
    yl        = $signed({1'b0, y_i[bwlp_pkg::SPLIT-1:0]});
    ph_1hz    = PHW'(coef_1hz_i) * PHW'(yh);
    pl_1hz    = PLW'(coef_1hz_i) * PLW'(yl);
    ph_halfhz = PHW'(coef_halfhz_i) * PHW'(yh);
    pl_halfhz = PLW'(coef_halfhz_i) * PLW'(yl);
    acc_1hz_d = (PW'(ph_1hz) <<< bwlp_pkg::SPLIT) + PW'(pl_1hz) + sum_1hz_i;
    acc_halfhz_d = (PW'(ph_halfhz) <<< bwlp_pkg::SPLIT) + PW'(pl_halfhz)
                 + sum_halfhz_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_1hz_q    <= '0;
      acc_halfhz_q <= '0;
    end else if (en_i) begin
      acc_1hz_q    <= acc_1hz_d;
      acc_halfhz_q <= acc_halfhz_d;
    end
  end

  assign sum_1hz_o    = acc_1hz_q;
  assign sum_halfhz_o = acc_halfhz_q;

endmodule

`default_nettype wire

/* rtl/butterworth_lowpass_iir4.sv */
// Top level of the fourth-order Butterworth low-pass IIR filter.
//
// Takes one unsigned ADC sample per transaction and returns one filtered sample, signed Q15.8,
// rounded and saturated, in the same order. A new sample is accepted every cycle unless the
// output stalls; a sample is registered in the feedforward stage and its result in the output
// register. That rate rests on the output recursion: the newest output is multiplied in each
// of a row of four feedback cells that hold the exact partial sums of both coefficient sets, so
// the next output needs only an add of the leading cell. The feedforward sum and its gain
// scaling sit one register ahead. cfg_data_i (0 = 1 Hz, 1 = 0.5 Hz corner at a 20 Hz sample
// rate) is to be written by the user with the block idle; the block does not enforce it. It acts
// on the next sample; both sets share one history. Any written value is accepted on every cycle.
`default_nettype none

module butterworth_lowpass_iir4 #(
  parameter int SAMPLE_WIDTH = 10,
  parameter int FRAC_BITS    = 24
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic                     cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [SAMPLE_WIDTH-1:0]  sample_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [bwlp_pkg::OUT_W-1:0] filtered_o
);

  localparam int HW  = SAMPLE_WIDTH + 2 + FRAC_BITS;
  localparam int FFW = SAMPLE_WIDTH + FRAC_BITS;
  localparam int PW  = HW + bwlp_pkg::COEF_W + 2;
  localparam int FBW = PW - bwlp_pkg::COEF_FRAC;
  localparam int YSW = FBW + 1;
  localparam int OSH = FRAC_BITS - 8;
  localparam int OW  = HW + 1 - OSH;
  localparam logic signed [PW-1:0]  FB_ROUND = PW'(1) <<< (bwlp_pkg::COEF_FRAC - 1);
  localparam logic signed [YSW-1:0] YMAX = YSW'((64'sd1 <<< (HW - 1)) - 64'sd1);
  localparam logic signed [YSW-1:0] YMIN = -YMAX - YSW'(1);
  localparam logic signed [HW:0]    OUT_ROUND = (HW+1)'(1) <<< (FRAC_BITS - 9);
  localparam logic signed [31:0]    OMAX = 32'sd8388607;
  localparam logic signed [31:0]    OMIN = -32'sd8388608;

  bwlp_pkg::corner_e corner_q;
  logic              v1_q;
  logic              vo_q;
  logic signed [bwlp_pkg::OUT_W-1:0] filtered_q, filtered_d;

  logic              in_acc;
  logic              out_free;
  logic              adv1;
  logic [FFW-1:0]    ffq;

  logic signed [PW-1:0]  s1hz    [5];
  logic signed [PW-1:0]  shalfhz [5];
  logic signed [PW-1:0]  p_sel;
  logic signed [PW-1:0]  p_rnd;
  logic signed [FBW-1:0] fb;
  logic signed [YSW-1:0] ysum;
  logic signed [HW-1:0]  y_new;
  logic signed [HW:0]    yr;
  logic signed [OW-1:0]  o_sh;
  logic signed [31:0]    o_ext;

  // handshake
  assign cfg_ready_o = 1'b1;
  assign out_free    = !vo_q || !out_stall_i;
  assign adv1        = v1_q && out_free;
  assign in_stall_o  = v1_q && !out_free;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = vo_q;
  assign filtered_o  = filtered_q;

  bwlp_ff #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_ff (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_acc),
    .sample_i (sample_i),
    .corner_i (corner_q),
    .ffq_o    (ffq)
  );

  assign s1hz[4]    = '0;
  assign shalfhz[4] = '0;

  // cell k weights the newest output with the coefficient of lag k+1
  for (genvar k = 0; k < 4; k++) begin : g_cell
    bwlp_fb_cell #(
      .HW (HW),
      .PW (PW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .en_i          (adv1),
      .y_i           (y_new),
      .coef_1hz_i    (bwlp_pkg::FB_COEF_1HZ[3-k]),
      .coef_halfhz_i (bwlp_pkg::FB_COEF_HALFHZ[3-k]),
      .sum_1hz_i     (s1hz[k+1]),
      .sum_halfhz_i  (shalfhz[k+1]),
      .sum_1hz_o     (s1hz[k]),
      .sum_halfhz_o  (shalfhz[k])
    );
  end

  always_comb begin
    p_sel = (corner_q == bwlp_pkg::CORNER_HALFHZ) ? shalfhz[0] : s1hz[0];
    p_rnd = p_sel + FB_ROUND;
    fb    = p_rnd[PW-1:bwlp_pkg::COEF_FRAC];
    ysum  = YSW'($signed({1'b0, ffq})) + YSW'(fb);
    // saturate to the history range
    if (ysum > YMAX) begin
      y_new = HW'(YMAX);
    end else if (ysum < YMIN) begin
      y_new = HW'(YMIN);
    end else begin
      y_new = HW'(ysum);
    end
    yr    = (HW+1)'(y_new) + OUT_ROUND;
    o_sh  = yr[HW:OSH];
    o_ext = 32'(o_sh);
    if (o_ext > OMAX) begin
      filtered_d = bwlp_pkg::OUT_W'(OMAX);
    end else if (o_ext < OMIN) begin
      filtered_d = bwlp_pkg::OUT_W'(OMIN);
    end else begin
      filtered_d = o_ext[bwlp_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= bwlp_pkg::CORNER_1HZ;
      v1_q     <= 1'b0;
      vo_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        corner_q <= bwlp_pkg::corner_e'(cfg_data_i);
      end
      if (in_acc) begin
        v1_q <= 1'b1;
      end else if (adv1) begin
        v1_q <= 1'b0;
      end
      if (adv1) begin
        vo_q <= 1'b1;
      end else if (!out_stall_i) begin
        vo_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      filtered_q <= filtered_d;
    end
  end

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> !in_stall_o)
    else $error("input stalled with an empty feedforward stage");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> v1_q)
    else $error("accepted transaction lost before the feedback stage");

  a_adv_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv1 |=> out_valid_o)
    else $error("computed output not presented");

  a_chain_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv1 |=> ($stable(s1hz[0]) && $stable(shalfhz[0])))
    else $error("feedback chain moved without an output");

endmodule

`default_nettype wire

/* tb/tb_butterworth_lowpass_iir4.sv */
// Self-checking testbench for the fourth-order Butterworth low-pass IIR filter.
`timescale 1ns / 1ps

module tb_butterworth_lowpass_iir4;

  localparam int SAMPLE_W    = 10;
  localparam int Y_FRAC      = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 10;

  // Reciprocal gains, unsigned Q0.40, rounded to nearest
  localparam logic [63:0] RECIP_1HZ =
    ((64'd1 << 40) * 64'd1000000 + 64'd1200194323) / 64'd2400388646;
  localparam logic [63:0] RECIP_HALFHZ =
    ((64'd1 << 40) * 64'd100000 + 64'd1600564581) / 64'd3201129162;

  // Output history range, Q11.24
  localparam logic signed [127:0] Y_MAX = 128'sd34359738367;
  localparam logic signed [127:0] Y_MIN = -128'sd34359738368;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic                  cfg_data_i  = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [SAMPLE_W-1:0]   sample_i    = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [bwlp_pkg::OUT_W-1:0] filtered_o;

  // Filter state mirrored on the testbench side
  logic [SAMPLE_W-1:0]   hist_x [4] = '{default: '0};
  logic signed [35:0]    hist_y [4] = '{default: '0};
  bwlp_pkg::corner_e     corner_sel = bwlp_pkg::CORNER_1HZ;

  logic signed [bwlp_pkg::OUT_W-1:0] pending_filtered [$];
  int                      mismatch_count = 0;
  int                      cycle_count    = 0;
  int                      hold_left      = 0;
  int                      sender_idle_pct = 0;
  int                      stall_pct       = 0;

  butterworth_lowpass_iir4 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Signed Q3.28 feedback weight; tap 0 weights the oldest output
  function automatic logic signed [31:0] feedback_weight(bwlp_pkg::corner_e c,
                                                         logic [1:0] tap);
    logic [63:0] decimal;
    logic [63:0] mag;
    if (c == bwlp_pkg::CORNER_1HZ) begin
      case (tap)
        2'd0: decimal = 64'd4382651423;
        2'd1: decimal = 64'd21121553551;
        2'd2: decimal = 64'd38611943490;
        default: decimal = 64'd31806385489;
      endcase
    end else begin
      case (tap)
        2'd0: decimal = 64'd6630104844;
        2'd1: decimal = 64'd29240526562;
        2'd2: decimal = 64'd48512758825;
        default: decimal = 64'd35897338871;
      endcase
    end
    mag = (decimal * 64'd268435456 + 64'd5000000000) / 64'd10000000000;
    return tap[0] ? $signed(mag[31:0]) : -$signed(mag[31:0]);
  endfunction

  // Advance the mirrored filter by one sample and return the Q15.8 output
  function automatic logic signed [bwlp_pkg::OUT_W-1:0] predict_filtered(
      logic [SAMPLE_W-1:0] x);
    logic [63:0]         recip;
    logic [63:0]         ff_sum;
    logic [63:0]         ff_scaled;
    logic signed [127:0] fb_acc;
    logic signed [127:0] y_wide;
    logic signed [127:0] y_round;
    recip = (corner_sel == bwlp_pkg::CORNER_HALFHZ) ? RECIP_HALFHZ : RECIP_1HZ;
    ff_sum = 64'(hist_x[0]) + 64'(x) + 64'd4 * (64'(hist_x[1]) + 64'(hist_x[3]))
           + 64'd6 * 64'(hist_x[2]);
    ff_scaled = (ff_sum * recip + (64'd1 << (39 - Y_FRAC))) >> (40 - Y_FRAC);
    fb_acc = '0;
    for (int k = 0; k < 4; k++)
      fb_acc = fb_acc + 128'(feedback_weight(corner_sel, 2'(k))) * 128'(hist_y[k]);
    y_wide = ((fb_acc + 128'sd134217728) >>> 28) + 128'($signed({1'b0, ff_scaled}));
    if (y_wide > Y_MAX) y_wide = Y_MAX;
    if (y_wide < Y_MIN) y_wide = Y_MIN;
    for (int k = 0; k < 3; k++) begin
      hist_x[k] = hist_x[k+1];
      hist_y[k] = hist_y[k+1];
    end
    hist_x[3] = x;
    hist_y[3] = y_wide[35:0];
    y_round = (y_wide + (128'sd1 <<< (Y_FRAC - 9))) >>> (Y_FRAC - 8);
    if (y_round > 128'sd8388607) y_round = 128'sd8388607;
    if (y_round < -128'sd8388608) y_round = -128'sd8388608;
    return y_round[bwlp_pkg::OUT_W-1:0];
  endfunction

  // Count down the long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Check each output transaction and drive the output stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_filtered.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected output: filtered %0d", filtered_o);
        mismatch_count++;
      end else if (filtered_o !== pending_filtered[0]) begin
        if (mismatch_count < 10)
          $display("filtered mismatch: expected %0d, got %0d",
                   pending_filtered[0], filtered_o);
        mismatch_count++;
        void'(pending_filtered.pop_front());
      end else begin
        void'(pending_filtered.pop_front());
      end
    end
    out_stall_i <= (hold_left > 0) ||
                   (stall_pct != 0 && $urandom_range(99, 0) < stall_pct);
  end

  // Offer one sample, hold it until accepted, then predict its output
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_filtered.push_back(predict_filtered(s));
  endtask

  // Stop sending and wait for every outstanding output
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_corner(input bwlp_pkg::corner_e c);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    corner_sel = c;
    @(posedge clk_i);
  endtask

  task automatic run_random_stream(input int count);
    int                  mode;
    int                  run_len;
    logic [SAMPLE_W-1:0] level;
    logic [SAMPLE_W-1:0] s;
    while (count > 0) begin
      mode    = $urandom_range(3, 0);
      run_len = $urandom_range(40, 1);
      level   = SAMPLE_W'($urandom_range(1023, 0));
      for (int i = 0; i < run_len && count > 0; i++) begin
        case (mode)
          0: s = SAMPLE_W'($urandom_range(1023, 0));
          1: s = level;
          2: s = level + SAMPLE_W'(i * 7);
          default: s = $urandom_range(1, 0) ? '1 : '0;
        endcase
        send_sample(s);
        count--;
      end
    end
  endtask

  // Extremes and steps on the reset corner, then a corner switch with history kept
  task automatic test_directed();
    send_sample('0);
    send_sample('0);
    repeat (8) send_sample('1);
    repeat (3) send_sample('0);
    repeat (2) begin
      send_sample('1);
      send_sample('0);
    end
    send_sample(10'd1);
    send_sample(10'h2AA);
    drain_outputs();
    write_corner(bwlp_pkg::CORNER_HALFHZ);
    send_sample('1);
    send_sample(10'h155);
    send_sample('0);
    send_sample('1);
    drain_outputs();
  endtask

  // Random traffic across the idling phases, corner changed between phases
  task automatic test_idle_phases();
    int sender_pct [4] = '{0, 88, 0, 29};
    int recv_pct   [4] = '{0, 0, 88, 29};
    for (int p = 0; p < 4; p++) begin
      write_corner(p[0] ? bwlp_pkg::CORNER_1HZ : bwlp_pkg::CORNER_HALFHZ);
      sender_idle_pct = sender_pct[p];
      stall_pct       = recv_pct[p];
      run_random_stream(450);
      drain_outputs();
    end
    sender_idle_pct = 0;
    stall_pct       = 0;
  endtask

  // Long receiver hold-off while samples keep coming, so the input stalls
  task automatic test_backpressure();
    write_corner(bwlp_pkg::CORNER_1HZ);
    hold_left <= HOLD_CYCLES;
    run_random_stream(80);
    drain_outputs();
    write_corner(bwlp_pkg::CORNER_HALFHZ);
    hold_left <= HOLD_CYCLES;
    run_random_stream(80);
    drain_outputs();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_idle_phases();
    test_backpressure();
    drain_outputs();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_filtered.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
